FILE: design/srtl_pkg.sv
// Package: shared types and constants for the sorted record table lookup.
`default_nettype none
package srtl_pkg;
  localparam int Depth = 1024;
  localparam int AddrW = 10;
  localparam int CntW = 11;

  localparam logic [1:0] ACT_ADD = 2'd0;
  localparam logic [1:0] ACT_FIND = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;
  localparam logic [1:0] ACT_IGNORE = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [1:0] action;
    logic [48:0] number;
    logic [4:0] area_code;
    logic [6:0] prefs;
    logic [1:0] kind;
    logic active_in;
    logic [9:0] position;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [10:0] found_index;
    logic [48:0] number_out;
    logic [4:0] area_out;
    logic [6:0] prefs_out;
    logic [1:0] kind_out;
    logic active_out;
    logic [10:0] entry_count;
  } out_t;

  typedef struct packed {
    logic [1:0] action;
    logic [63:0] rec;
    logic [9:0] position;
  } cmd_t;
endpackage
`default_nettype wire

FILE: design/srtl_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
`default_nettype none
module srtl_ram #(
  parameter int Width = 64,
  parameter int Dep = 1024,
  parameter int AW = $clog2(Dep)
) (
  input wire logic clk,
  input wire logic we,
  input wire logic [AW-1:0] waddr,
  input wire logic [Width-1:0] wdata,
  input wire logic [AW-1:0] raddr,
  output logic [Width-1:0] rdata
);
  logic [Width-1:0] mem [Dep];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: design/srtl_front.sv
// Front end: accepts transactions, packs records, and fills the command queue.
`default_nettype none
module srtl_front (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  output logic in_stall,
  input wire srtl_pkg::in_t in_data,
  output logic q_valid,
  input wire logic q_take,
  output srtl_pkg::cmd_t q_data
);
  srtl_pkg::cmd_t buf0;
  srtl_pkg::cmd_t buf1;
  logic [1:0] fill;
  logic push;
  srtl_pkg::cmd_t cmd;

  assign in_stall = (fill == 2'd2);
  assign push = in_valid && !in_stall;
  assign q_valid = (fill != 2'd0);
  assign q_data = buf0;

  always_comb begin
    cmd.action = in_data.action;
    cmd.rec = {in_data.number, in_data.area_code, in_data.prefs, in_data.kind,
               in_data.active_in};
    cmd.position = in_data.position;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
    end else begin
      case ({push, q_take})
        2'b10: fill <= fill + 2'd1;
        2'b01: fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
    if (q_take) begin
      buf0 <= (fill == 2'd2) ? buf1 : cmd;
      if (push) begin
        buf1 <= cmd;
      end
    end else if (push) begin
      if (fill == 2'd0) begin
        buf0 <= cmd;
      end else begin
        buf1 <= cmd;
      end
    end
  end

  a_fill: assert property (@(posedge clk) disable iff (rst) fill != 2'd3)
    else $error("queue overfull");
  a_take: assert property (@(posedge clk) disable iff (rst) q_take |-> q_valid)
    else $error("take from empty queue");
  a_stall: assert property (@(posedge clk) disable iff (rst) in_stall |-> q_valid)
    else $error("stall with empty queue");
endmodule
`default_nettype wire

FILE: design/srtl_back.sv
// Back end: table storage, insertion sort, binary search and result register.
`default_nettype none
module srtl_back (
  input wire logic clk,
  input wire logic rst,
  input wire logic q_valid,
  output logic q_take,
  input wire srtl_pkg::cmd_t q_data,
  output logic out_valid,
  input wire logic out_stall,
  output srtl_pkg::out_t out_data
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SI = 4'd1;
  localparam logic [3:0] S_SV = 4'd2;
  localparam logic [3:0] S_SC = 4'd3;
  localparam logic [3:0] S_SW = 4'd4;
  localparam logic [3:0] S_BR = 4'd5;
  localparam logic [3:0] S_BW = 4'd6;
  localparam logic [3:0] S_FR = 4'd7;
  localparam logic [3:0] S_FW = 4'd8;
  localparam logic [3:0] S_RW = 4'd9;

  logic [3:0] state;
  logic [srtl_pkg::CntW-1:0] count;
  logic is_sorted;
  logic [srtl_pkg::CntW-1:0] i;
  logic [srtl_pkg::CntW-1:0] j;
  logic [srtl_pkg::CntW-1:0] lo;
  logic [srtl_pkg::CntW-1:0] hi;
  logic [srtl_pkg::CntW-1:0] mid;
  logic [63:0] v;
  logic [63:0] key;
  srtl_pkg::cmd_t cur;
  logic [srtl_pkg::CntW-1:0] rpos;

  logic we;
  logic [srtl_pkg::AddrW-1:0] waddr;
  logic [63:0] wdata;
  logic [srtl_pkg::AddrW-1:0] raddr;
  logic [63:0] rdata;

  srtl_ram #(.Width(64), .Dep(srtl_pkg::Depth)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign mid = lo + ((hi - lo) >> 1);
  assign q_take = (state == S_IDLE) && q_valid && !(out_valid && out_stall);
  assign rpos = {1'b0, q_data.position};

  always_comb begin
    we = 1'b0;
    waddr = j[srtl_pkg::AddrW-1:0];
    wdata = v;
    raddr = mid[srtl_pkg::AddrW-1:0];
    case (state)
      S_IDLE: begin
        raddr = q_data.position;
        if (q_take && q_data.action == srtl_pkg::ACT_ADD && count < srtl_pkg::Depth) begin
          we = 1'b1;
          waddr = count[srtl_pkg::AddrW-1:0];
          wdata = q_data.rec;
        end
      end
      S_SI: raddr = i[srtl_pkg::AddrW-1:0];
      S_SV: raddr = j[srtl_pkg::AddrW-1:0] - 1'b1;
      S_SC: begin
        raddr = j[srtl_pkg::AddrW-1:0] - 1'b1;
        if (j != '0 && rdata > v) begin
          we = 1'b1;
          wdata = rdata;
        end else begin
          we = 1'b1;
        end
      end
      S_SW: raddr = j[srtl_pkg::AddrW-1:0] - 1'b1;
      S_FR: raddr = lo[srtl_pkg::AddrW-1:0];
      default: ;
    endcase
  end

  function automatic srtl_pkg::out_t mk(logic [1:0] st, logic [10:0] idx, logic [63:0] rec,
                                        logic have, logic [10:0] cnt);
    srtl_pkg::out_t o;
    logic [63:0] r;
    r = have ? rec : 64'd0;
    o.status = st;
    o.found_index = idx;
    o.number_out = r[63:15];
    o.area_out = r[14:10];
    o.prefs_out = r[9:3];
    o.kind_out = r[2:1];
    o.active_out = r[0];
    o.entry_count = cnt;
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      is_sorted <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_take) begin
            cur <= q_data;
            case (q_data.action)
              srtl_pkg::ACT_ADD: begin
                out_valid <= 1'b1;
                if (count < srtl_pkg::Depth) begin
                  out_data <= mk(srtl_pkg::ST_OK, count, q_data.rec, 1'b1, count + 1'b1);
                  count <= count + 1'b1;
                  is_sorted <= 1'b0;
                end else begin
                  out_data <= mk(srtl_pkg::ST_FULL, count, 64'd0, 1'b0, count);
                end
              end
              srtl_pkg::ACT_FIND: begin
                key <= {q_data.rec[63:15], 15'd0};
                lo <= '0;
                hi <= count;
                i <= 11'd1;
                state <= is_sorted ? S_BR : S_SI;
              end
              srtl_pkg::ACT_READ: begin
                if (rpos >= count) begin
                  out_valid <= 1'b1;
                  out_data <= mk(srtl_pkg::ST_RANGE, rpos, 64'd0, 1'b0, count);
                end else begin
                  state <= S_RW;
                end
              end
              default: begin
                out_valid <= 1'b1;
                out_data <= mk(srtl_pkg::ST_OK, count, 64'd0, 1'b0, count);
              end
            endcase
          end
        end
        S_SI: begin
          if (i >= count) begin
            is_sorted <= 1'b1;
            state <= S_BR;
          end else begin
            j <= i;
            state <= S_SV;
          end
        end
        S_SV: begin
          v <= rdata;
          state <= S_SC;
        end
        S_SC: begin
          if (j != '0 && rdata > v) begin
            j <= j - 1'b1;
            state <= S_SW;
          end else begin
            i <= i + 1'b1;
            state <= S_SI;
          end
        end
        S_SW: state <= (j == '0) ? S_SC : S_SC;
        S_BR: begin
          if (lo < hi) begin
            state <= S_BW;
          end else begin
            state <= S_FR;
          end
        end
        S_BW: begin
          if (rdata < key) begin
            lo <= mid + 1'b1;
          end else begin
            hi <= mid;
          end
          state <= S_BR;
        end
        S_FR: state <= S_FW;
        S_FW: begin
          out_valid <= 1'b1;
          if (lo < count && rdata[63:15] == key[63:15]) begin
            out_data <= mk(srtl_pkg::ST_OK, lo, rdata, 1'b1, count);
          end else begin
            out_data <= mk(srtl_pkg::ST_NOTFOUND, count, 64'd0, 1'b0, count);
          end
          state <= S_IDLE;
        end
        S_RW: begin
          out_valid <= 1'b1;
          out_data <= mk(srtl_pkg::ST_OK, {1'b0, cur.position}, rdata, 1'b1, count);
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_cnt: assert property (@(posedge clk) disable iff (rst) count <= srtl_pkg::Depth)
    else $error("count overflow");
  a_bs: assert property (@(posedge clk) disable iff (rst) state == S_BW |-> lo < hi)
    else $error("search bounds crossed");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result dropped under stall");
endmodule
`default_nettype wire

FILE: design/sorted_record_table_lookup.sv
// Top level of the sorted record table lookup block.
// Input channel (in_valid/in_stall/in_data) carries add, find and read
// transactions; output channel (out_valid/out_stall/out_data) returns one
// result per transaction, in order.
// A two-entry command queue separates the front end from the back end.
// A find on a sorted table runs a binary search; the first find after adds
// first runs an insertion sort of the records through the single table RAM.
// Throughput is one transaction at a time in the back end; the front end
// keeps accepting until the queue holds two.
// Reset empties the table and the queue; no clearing pass is needed.
// While out_stall is high the result holds and the back end waits.
`default_nettype none
module sorted_record_table_lookup (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  output logic in_stall,
  input wire srtl_pkg::in_t in_data,
  output logic out_valid,
  input wire logic out_stall,
  output srtl_pkg::out_t out_data
);
  logic q_valid;
  logic q_take;
  srtl_pkg::cmd_t q_data;

  srtl_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .q_valid(q_valid), .q_take(q_take), .q_data(q_data)
  );

  srtl_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_take(q_take), .q_data(q_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );
endmodule
`default_nettype wire
